// ----- src/qti_pkg.sv -----
// Shared types, codes and fixed-point helpers of the quintic trajectory interpolator.
package qti_pkg;

	localparam int COEF_W = 48;
	localparam int T_W    = 32;
	localparam int TS_W   = 22;
	localparam int PROD_W = 59;
	localparam int NCOEF  = 6;
	localparam int DIGIT_W = 4;

	localparam logic [1:0] OP_LOAD_COEF = 2'd0;
	localparam logic [1:0] OP_LOAD_LEN  = 2'd1;
	localparam logic [1:0] OP_TICK      = 2'd2;
	localparam logic [1:0] OP_START     = 2'd3;

	localparam logic [1:0] KIND_SAMPLE  = 2'd0;
	localparam logic [1:0] KIND_ADVANCE = 2'd1;
	localparam logic [1:0] KIND_DONE    = 2'd2;
	localparam logic [1:0] KIND_IDLE    = 2'd3;

	localparam logic [1:0] CH_ANGLE = 2'd0;
	localparam logic [1:0] CH_SPEED = 2'd1;
	localparam logic [1:0] CH_ACCEL = 2'd2;

	localparam logic [5:0] SEGCNT_RESET = 6'd1;
	localparam logic [TS_W-1:0] TSTEP_RESET = 22'd20972;

	localparam logic REG_SEGCNT = 1'b0;
	localparam logic REG_TSTEP  = 1'b1;

	typedef logic signed [COEF_W-1:0] coef_t;

	typedef struct packed {
		logic [1:0]         operation;
		logic [4:0]         segment;
		logic [1:0]         joint;
		logic [2:0]         coef_index;
		logic signed [47:0] value;
	} qti_in_t;

	typedef struct packed {
		logic [1:0]         kind;
		logic [1:0]         joint_out;
		logic [4:0]         segment_out;
		logic signed [31:0] angle;
		logic signed [31:0] speed;
		logic signed [31:0] accel;
		logic               last;
	} qti_out_t;

	typedef struct packed {
		logic signed [31:0] angle;
		logic signed [31:0] speed;
		logic signed [31:0] accel;
	} qti_eval_t;

	// Horner weight of power i in chain ch
	function automatic logic [4:0] kfactor(input logic [1:0] ch, input logic [2:0] i);
		logic [4:0] k;
		k = 5'd0;
		case (ch)
			CH_ANGLE: k = 5'd1;
			CH_SPEED: k = {2'b00, i};
			CH_ACCEL: begin
				case (i)
					3'd2: k = 5'd2;
					3'd3: k = 5'd6;
					3'd4: k = 5'd12;
					3'd5: k = 5'd20;
					default: k = 5'd0;
				endcase
			end
			default: k = 5'd0;
		endcase
		return k;
	endfunction

	function automatic coef_t scale(input coef_t a, input logic [4:0] k);
		logic signed [53:0] p;
		p = 54'(a) * 54'($signed({1'b0, k}));
		if (p > 54'sd140737488355327)
			return 48'sh7FFF_FFFF_FFFF;
		else if (p < -54'sd140737488355328)
			return 48'sh8000_0000_0000;
		else
			return p[47:0];
	endfunction

	function automatic coef_t sat_sum(input logic signed [PROD_W-1:0] prod, input coef_t s);
		logic signed [PROD_W:0] x;
		x = (PROD_W+1)'(prod) + (PROD_W+1)'(s);
		if (x > 60'sd140737488355327)
			return 48'sh7FFF_FFFF_FFFF;
		else if (x < -60'sd140737488355328)
			return 48'sh8000_0000_0000;
		else
			return x[47:0];
	endfunction

	function automatic logic signed [31:0] to_q824(input coef_t x);
		logic signed [39:0] y;
		y = x[47:8];
		if (y > 40'sd2147483647)
			return 32'sh7FFF_FFFF;
		else if (y < -40'sd2147483648)
			return 32'sh8000_0000;
		else
			return y[31:0];
	endfunction

endpackage

// ----- src/qti_mul.sv -----
// Digit-serial signed-by-unsigned multiplier, four bits of t per cycle, floor shift by 22.
module qti_mul import qti_pkg::*; (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     go,
	input  coef_t                    a,
	input  logic [T_W-1:0]           t,
	output logic                     done,
	output logic signed [PROD_W-1:0] prod
);

	localparam int DIGITS = T_W / DIGIT_W;
	localparam int CW = $clog2(DIGITS);

	logic               busy_q;
	logic [CW-1:0]      cnt_q;
	logic               done_q;
	coef_t              a_q;
	logic [T_W-1:0]     t_q;
	logic signed [48:0] hi_q;
	logic [T_W-1:0]     lo_q;
	logic signed [53:0] sum;

	// add one digit's partial product to the running high part
	assign sum = 54'(hi_q) + 54'(a_q) * 54'($signed({1'b0, t_q[DIGIT_W-1:0]}));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= busy_q && (cnt_q == CW'(DIGITS - 1));
			if (go && !busy_q) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(DIGITS - 1)) begin
					busy_q <= 1'b0;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (go && !busy_q) begin
			a_q  <= a;
			t_q  <= t;
			hi_q <= '0;
			lo_q <= '0;
		end else if (busy_q) begin
			hi_q <= 49'(sum >>> DIGIT_W);
			lo_q <= {sum[DIGIT_W-1:0], lo_q[T_W-1:DIGIT_W]};
			t_q  <= t_q >> DIGIT_W;
		end
	end

	assign done = done_q;
	assign prod = $signed({hi_q, lo_q[T_W-1:22]});

endmodule

// ----- src/qti_horner.sv -----
// Sequencer of the three Horner chains of one joint over the shared serial multiplier.
module qti_horner import qti_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           start,
	input  coef_t          a [NCOEF],
	input  logic [T_W-1:0] t,
	output logic           done,
	output qti_eval_t      res
);

	logic [1:0]                ch_q;
	logic [2:0]                i_q;
	coef_t                     acc_q;
	logic                      go_q;
	logic                      done_q;
	qti_eval_t                 res_q;
	logic                      mul_done;
	logic signed [PROD_W-1:0]  prod;
	coef_t                     nxt;
	coef_t                     top_next;
	logic                      at_bottom;

	qti_mul u_mul (
		.clk    (clk),
		.arst_n (arst_n),
		.go     (go_q),
		.a      (acc_q),
		.t      (t),
		.done   (mul_done),
		.prod   (prod)
	);

	// lowest power of each chain equals its chain number
	assign at_bottom = (i_q == {1'b0, ch_q});
	assign nxt       = sat_sum(prod, scale(a[i_q], kfactor(ch_q, i_q)));
	assign top_next  = scale(a[5], kfactor(ch_q + 2'd1, 3'd5));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ch_q   <= CH_ANGLE;
			i_q    <= 3'd4;
			go_q   <= 1'b0;
			done_q <= 1'b0;
		end else begin
			go_q   <= start || (mul_done && !(at_bottom && ch_q == CH_ACCEL));
			done_q <= !start && mul_done && at_bottom && (ch_q == CH_ACCEL);
			if (start) begin
				ch_q <= CH_ANGLE;
				i_q  <= 3'd4;
			end else if (mul_done) begin
				if (at_bottom) begin
					if (ch_q != CH_ACCEL) begin
						ch_q <= ch_q + 2'd1;
						i_q  <= 3'd4;
					end
				end else begin
					i_q <= i_q - 3'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= scale(a[5], kfactor(CH_ANGLE, 3'd5));
		end else if (mul_done) begin
			acc_q <= at_bottom ? top_next : nxt;
			if (at_bottom) begin
				case (ch_q)
					CH_ANGLE: res_q.angle <= to_q824(nxt);
					CH_SPEED: res_q.speed <= to_q824(nxt);
					default:  res_q.accel <= to_q824(nxt);
				endcase
			end
		end
	end

	assign done = done_q;
	assign res  = res_q;

endmodule

// ----- src/quintic_trajectory_interpolator_unit.sv -----
// Top level of the quintic trajectory interpolator: stores, tick control and result register.
//
// Loads, starts and ticks arrive as items on the req channel; loads and starts give no
// result. A tick while no path runs gives its one result through S_NOTE, which loads it
// into the output register once that is free; a tick that moves to the next segment or
// ends the path goes through S_CHECK and then S_NOTE before its result is loaded.
// A sampling tick gives one result per joint: each joint reads its six coefficients from the
// coefficient memory and then takes twelve Horner steps on one shared multiplier that takes
// four bits of t per cycle. req_stall stays high from a tick until its last result sits in
// the output register. The coefficient and length memories come out of reset holding
// nothing; entries must be loaded before a path reads them. t = count * time_step saturates
// at the top of Q10.22; all Horner sums saturate in Q16.32 and the outputs saturate in Q8.24.
module quintic_trajectory_interpolator_unit import qti_pkg::*; #(
	parameter int MAX_SEGMENTS = 32,
	parameter int JOINT_COUNT  = 4,
	parameter int TICK_BITS    = 16
) (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            req_valid,
	output logic            req_stall,
	input  qti_in_t         req,
	output logic            rsp_valid,
	input  logic            rsp_stall,
	output qti_out_t        rsp,
	input  logic            cfg_valid,
	output logic            cfg_ready,
	input  logic            cfg_index,
	input  logic [TS_W-1:0] cfg_data
);

	localparam int SEGB   = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
	localparam int JB     = (JOINT_COUNT > 1) ? $clog2(JOINT_COUNT) : 1;
	localparam int ROWS   = MAX_SEGMENTS * JOINT_COUNT;
	localparam int ROWW   = (ROWS > 1) ? $clog2(ROWS) : 1;
	localparam int CDEPTH = ROWS * 8;
	localparam int MW     = (TICK_BITS + TS_W + 1 > T_W + 1) ? TICK_BITS + TS_W + 1 : T_W + 1;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_FETCH,
		S_EVAL,
		S_EMIT,
		S_NOTE
	} state_t;

	state_t                state_q;
	logic                  running_q;
	logic [SEGB-1:0]       cur_q;
	logic [TICK_BITS-1:0]  tick_q;
	logic [JB-1:0]         j_q;
	logic [2:0]            fc_q;
	logic                  start_q;
	logic [1:0]            note_kind_q;
	logic [T_W-1:0]        t_q;
	logic                  rsp_valid_q;
	qti_out_t              rsp_q;
	logic [5:0]            segcnt_q;
	logic [TS_W-1:0]       tstep_q;

	coef_t                 cmem [CDEPTH];
	logic [TICK_BITS-1:0]  lmem [MAX_SEGMENTS];
	coef_t                 rdata_q;
	logic [TICK_BITS-1:0]  len_q;
	coef_t                 a_q [NCOEF];

	logic                  accept;
	logic                  out_free;
	logic                  rsp_load;
	logic                  ld_ok;
	logic [ROWW:0]         ld_row_w;
	logic [ROWW:0]         ev_row_w;
	logic [TICK_BITS:0]    next_cnt;
	logic [MW-1:0]         t_wide;
	logic [T_W-1:0]        t_sat;
	logic [8:0]            cnt_eff;
	logic                  path_end;
	logic [TICK_BITS-1:0]  len_in;
	logic                  hz_done;
	qti_eval_t             hz_res;

	assign accept    = req_valid && (state_q == S_IDLE);
	assign req_stall = (state_q != S_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;
	assign rsp_load  = out_free && (state_q == S_EMIT || state_q == S_NOTE);
	assign cfg_ready = 1'b1;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			segcnt_q <= SEGCNT_RESET;
			tstep_q  <= TSTEP_RESET;
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_SEGCNT: segcnt_q <= cfg_data[5:0];
				REG_TSTEP:  tstep_q  <= cfg_data;
				default:    tstep_q  <= tstep_q;
			endcase
		end
	end

	// memory rows: one per segment and joint, eight coefficient slots each
	assign ld_row_w = (ROWW+1)'(req.segment) * (ROWW+1)'(JOINT_COUNT) + (ROWW+1)'(req.joint);
	assign ev_row_w = (ROWW+1)'(cur_q) * (ROWW+1)'(JOINT_COUNT) + (ROWW+1)'(j_q);
	assign ld_ok    = (32'(req.segment) < 32'(MAX_SEGMENTS)) &&
	                  (32'(req.joint) < 32'(JOINT_COUNT)) &&
	                  (req.coef_index < 3'(NCOEF));

	// clamp a loaded length into the counter range
	always_comb begin
		if (req.value[47])
			len_in = '0;
		else if (|req.value[46:TICK_BITS])
			len_in = '1;
		else
			len_in = req.value[TICK_BITS-1:0];
	end

	always_ff @(posedge clk) begin
		if (accept && req.operation == OP_LOAD_COEF && ld_ok)
			cmem[{ld_row_w[ROWW-1:0], req.coef_index}] <= req.value;
		rdata_q <= cmem[{ev_row_w[ROWW-1:0], fc_q}];
	end

	always_ff @(posedge clk) begin
		if (accept && req.operation == OP_LOAD_LEN &&
		    32'(req.segment) < 32'(MAX_SEGMENTS))
			lmem[SEGB'(req.segment)] <= len_in;
		len_q <= lmem[cur_q];
	end

	// capture coefficient fc-1 while fc is issued
	always_ff @(posedge clk) begin
		if (state_q == S_FETCH && fc_q != 3'd0)
			a_q[3'(fc_q - 3'd1)] <= rdata_q;
	end

	// tick arithmetic
	assign next_cnt = (TICK_BITS+1)'(tick_q) + 1'b1;
	assign t_wide   = MW'(next_cnt) * MW'(tstep_q);
	assign t_sat    = (|t_wide[MW-1:T_W]) ? '1 : t_wide[T_W-1:0];

	always_comb begin
		if (segcnt_q == 6'd0)
			cnt_eff = 9'd1;
		else if (9'(segcnt_q) > 9'(MAX_SEGMENTS))
			cnt_eff = 9'(MAX_SEGMENTS);
		else
			cnt_eff = 9'(segcnt_q);
	end
	assign path_end = (9'(cur_q) + 9'd1) >= cnt_eff;

	qti_horner u_horner (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start_q),
		.a      (a_q),
		.t      (t_q),
		.done   (hz_done),
		.res    (hz_res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			running_q   <= 1'b0;
			cur_q       <= '0;
			tick_q      <= '0;
			j_q         <= '0;
			fc_q        <= '0;
			start_q     <= 1'b0;
			note_kind_q <= KIND_IDLE;
			t_q         <= '0;
			rsp_valid_q <= 1'b0;
			rsp_q       <= '0;
		end else begin
			// kick the Horner unit once the last coefficient is captured
			start_q <= (state_q == S_FETCH) && (fc_q == 3'(NCOEF));
			// drop the held result once taken, unless a new one replaces it
			if (rsp_valid_q && !rsp_stall && !rsp_load)
				rsp_valid_q <= 1'b0;
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						case (req.operation)
							OP_START: begin
								running_q <= 1'b1;
								cur_q     <= '0;
								tick_q    <= '0;
							end
							OP_TICK: begin
								if (running_q) begin
									state_q <= S_CHECK;
								end else begin
									note_kind_q <= KIND_IDLE;
									state_q     <= S_NOTE;
								end
							end
							default: state_q <= S_IDLE;
						endcase
					end
				end
				S_CHECK: begin
					if (next_cnt <= (TICK_BITS+1)'(len_q)) begin
						tick_q  <= next_cnt[TICK_BITS-1:0];
						t_q     <= t_sat;
						j_q     <= '0;
						fc_q    <= '0;
						state_q <= S_FETCH;
					end else begin
						tick_q      <= '0;
						note_kind_q <= path_end ? KIND_DONE : KIND_ADVANCE;
						state_q     <= S_NOTE;
					end
				end
				S_FETCH: begin
					if (fc_q == 3'(NCOEF)) begin
						state_q <= S_EVAL;
					end else begin
						fc_q <= fc_q + 3'd1;
					end
				end
				S_EVAL: begin
					if (hz_done)
						state_q <= S_EMIT;
				end
				S_EMIT: begin
					if (out_free) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.kind        <= KIND_SAMPLE;
						rsp_q.joint_out   <= 2'(j_q);
						rsp_q.segment_out <= 5'(cur_q);
						rsp_q.angle       <= hz_res.angle;
						rsp_q.speed       <= hz_res.speed;
						rsp_q.accel       <= hz_res.accel;
						rsp_q.last        <= (32'(j_q) == 32'(JOINT_COUNT - 1));
						if (32'(j_q) == 32'(JOINT_COUNT - 1)) begin
							state_q <= S_IDLE;
						end else begin
							j_q     <= j_q + 1'b1;
							fc_q    <= '0;
							state_q <= S_FETCH;
						end
					end
				end
				S_NOTE: begin
					if (out_free) begin
						rsp_valid_q       <= 1'b1;
						rsp_q.kind        <= note_kind_q;
						rsp_q.joint_out   <= 2'd0;
						rsp_q.segment_out <= 5'(cur_q);
						rsp_q.angle       <= '0;
						rsp_q.speed       <= '0;
						rsp_q.accel       <= '0;
						rsp_q.last        <= 1'b1;
						// advance or end the path on an advance or done note
						if (note_kind_q == KIND_DONE) begin
							running_q <= 1'b0;
							cur_q     <= '0;
						end else if (note_kind_q == KIND_ADVANCE) begin
							cur_q <= cur_q + 1'b1;
						end
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule
